// ===== hdl/team_slot_table_top_macros.svh =====
// assertion macros of the team slot table rtl
`ifndef TEAM_SLOT_TABLE_TOP_MACROS_SVH
`define TEAM_SLOT_TABLE_TOP_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define TST_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define TST_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/tst_pkg.sv =====
// shared types, codes and sizes of the team slot table
package tst_pkg;

  localparam int unsigned SLOTS_DEF = 64;
  localparam int unsigned ID_W      = 16;
  localparam int unsigned FIELD_W   = 6;
  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned STATUS_W  = 2;

  localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RECYCLE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CONVERT = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [ID_W-1:0]    team_id;
    logic [FIELD_W-1:0] slot_index;
    logic [FIELD_W-1:0] position;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FIELD_W-1:0]  slot_out;
    logic [FIELD_W-1:0]  position_out;
  } res_t;

endpackage

// ===== hdl/tst_ram.sv =====
// generic one-write one-read ram with registered read data
module tst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/tst_ctrl.sv =====
// sequencer, counters and table memories of the team slot table
`include "team_slot_table_top_macros.svh"

module tst_ctrl import tst_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  req_t            req_i,
  input  logic [ID_W-1:0] all_team_id_i,
  output logic            busy_o,
  output logic            res_valid_o,
  output res_t            res_o,
  input  logic            res_ready_i
);

  localparam int unsigned SW  = $clog2(SLOTS);
  localparam int unsigned CW  = SW + 1;
  localparam int unsigned SVW = (SW > FIELD_W) ? SW : FIELD_W;
  localparam int unsigned TW  = ID_W + SVW;

  typedef enum logic [2:0] {
    S_IDLE, S_ALLOC, S_SHIFT, S_SEARCH, S_CMP, S_FINAL, S_DONE
  } state_e;

  state_e         state_q, state_d;
  req_t           req_q, req_d;
  res_t           res_q, res_d;
  logic [CW-1:0]  free_cnt_q, free_cnt_d;
  logic [CW-1:0]  mark_q, mark_d;
  logic [CW-1:0]  tbl_cnt_q, tbl_cnt_d;
  logic [SW-1:0]  lo_q, lo_d;
  logic [SW-1:0]  hi_q, hi_d;
  logic [SW-1:0]  idx_q, idx_d;

  logic           stk_we;
  logic [SW-1:0]  stk_waddr, stk_raddr;
  logic [SVW-1:0] stk_wdata, stk_rdata;
  logic           tbl_we;
  logic [SW-1:0]  tbl_waddr, tbl_raddr;
  logic [TW-1:0]  tbl_wdata, tbl_rdata;

  logic [CW-1:0]   pop_idx;
  logic [SVW-1:0]  pop_slot;
  logic [ID_W-1:0] rd_id;
  logic [SVW-1:0]  rd_slot;
  logic [SW:0]     mid_sum;
  logic [SW-1:0]  mid;
  logic            id_lt, id_eq;

  tst_ram #(.WIDTH(SVW), .DEPTH(SLOTS)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  tst_ram #(.WIDTH(TW), .DEPTH(SLOTS)) u_table_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  // stack entries below the lowest depth ever reached were never written; their reset value is computed here
  assign pop_idx  = free_cnt_q - CW'(1);
  assign pop_slot = (pop_idx >= mark_q) ? stk_rdata : SVW'(CW'(SLOTS - 1) - pop_idx);

  assign rd_id   = tbl_rdata[TW-1 -: ID_W];
  assign rd_slot = tbl_rdata[SVW-1:0];
  // id comparators for the search steps: less-than in S_CMP, equal in S_FINAL
  assign id_lt   = rd_id < req_q.team_id;
  assign id_eq   = rd_id == req_q.team_id;
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[SW:1];

  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    res_d      = res_q;
    free_cnt_d = free_cnt_q;
    mark_d     = mark_q;
    tbl_cnt_d  = tbl_cnt_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    idx_d      = idx_q;
    stk_we     = 1'b0;
    stk_waddr  = free_cnt_q[SW-1:0];
    stk_wdata  = SVW'(req_i.slot_index);
    stk_raddr  = pop_idx[SW-1:0];
    tbl_we     = 1'b0;
    tbl_waddr  = idx_q;
    tbl_wdata  = tbl_rdata;
    tbl_raddr  = lo_q;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          req_d = req_i;
          res_d = '{status: ST_MISS, slot_out: '0, position_out: '0};
          state_d = S_DONE;
          case (req_i.func)
            FUNC_ALLOC: begin
              if (free_cnt_q == '0 || tbl_cnt_q == CW'(SLOTS)) begin
                res_d.status = ST_FULL;
              end else begin
                state_d = S_ALLOC;
              end
            end
            FUNC_RECYCLE: begin
              if (tbl_cnt_q != '0) begin
                res_d.status = ST_OK;
                // a push onto a full stack is dropped
                if (free_cnt_q != CW'(SLOTS)) begin
                  stk_we     = 1'b1;
                  free_cnt_d = free_cnt_q + CW'(1);
                end
                if ((32'(req_i.position) + 32'd1) < 32'(tbl_cnt_q)) begin
                  idx_d     = SW'(req_i.position);
                  tbl_raddr = SW'(32'(req_i.position) + 32'd1);
                  state_d   = S_SHIFT;
                end else begin
                  tbl_cnt_d = tbl_cnt_q - CW'(1);
                end
              end
            end
            FUNC_CONVERT: begin
              if (req_i.team_id == all_team_id_i) begin
                res_d.status = ST_OK;
              end else if (tbl_cnt_q != '0) begin
                lo_d    = '0;
                hi_d    = SW'(tbl_cnt_q - CW'(1));
                state_d = S_SEARCH;
              end
            end
            default: begin
              res_d.status = ST_MISS;
            end
          endcase
        end
      end
      S_ALLOC: begin
        tbl_we     = 1'b1;
        tbl_waddr  = tbl_cnt_q[SW-1:0];
        tbl_wdata  = {req_q.team_id, pop_slot};
        free_cnt_d = pop_idx;
        if (pop_idx < mark_q) begin
          mark_d = pop_idx;
        end
        tbl_cnt_d = tbl_cnt_q + CW'(1);
        res_d     = '{status: ST_OK, slot_out: pop_slot[FIELD_W-1:0],
                      position_out: FIELD_W'(tbl_cnt_q)};
        state_d   = S_DONE;
      end
      S_SHIFT: begin
        // entry idx+1 is on the read port, move it down to idx
        tbl_we    = 1'b1;
        tbl_waddr = idx_q;
        tbl_wdata = tbl_rdata;
        idx_d     = SW'(32'(idx_q) + 32'd1);
        if ((32'(idx_q) + 32'd2) < 32'(tbl_cnt_q)) begin
          tbl_raddr = SW'(32'(idx_q) + 32'd2);
        end else begin
          tbl_cnt_d = tbl_cnt_q - CW'(1);
          state_d   = S_DONE;
        end
      end
      S_SEARCH: begin
        if (lo_q < hi_q) begin
          tbl_raddr = mid;
          idx_d     = mid;
          state_d   = S_CMP;
        end else begin
          tbl_raddr = lo_q;
          state_d   = S_FINAL;
        end
      end
      S_CMP: begin
        if (id_lt) begin
          lo_d = SW'(32'(idx_q) + 32'd1);
        end else begin
          hi_d = idx_q;
        end
        state_d = S_SEARCH;
      end
      S_FINAL: begin
        if (id_eq) begin
          res_d = '{status: ST_OK, slot_out: FIELD_W'(rd_slot),
                    position_out: FIELD_W'(lo_q)};
        end else begin
          res_d = '{status: ST_MISS, slot_out: '0, position_out: '0};
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      req_q      <= '0;
      res_q      <= '0;
      free_cnt_q <= CW'(SLOTS);
      mark_q     <= CW'(SLOTS);
      tbl_cnt_q  <= '0;
      lo_q       <= '0;
      hi_q       <= '0;
      idx_q      <= '0;
    end else begin
      state_q    <= state_d;
      req_q      <= req_d;
      res_q      <= res_d;
      free_cnt_q <= free_cnt_d;
      mark_q     <= mark_d;
      tbl_cnt_q  <= tbl_cnt_d;
      lo_q       <= lo_d;
      hi_q       <= hi_d;
      idx_q      <= idx_d;
    end
  end

  assign busy_o      = state_q != S_IDLE;
  assign res_valid_o = state_q == S_DONE;
  assign res_o       = res_q;

  `TST_ASSERT_IMP(a_free_range, 1'b1, free_cnt_q <= CW'(SLOTS), "free count above slots")
  `TST_ASSERT_IMP(a_mark_below_free, 1'b1, mark_q <= free_cnt_q, "stack mark above free count")
  `TST_ASSERT_IMP(a_table_range, 1'b1, tbl_cnt_q <= CW'(SLOTS), "table count above slots")
  `TST_ASSERT_IMP(a_search_order, state_q == S_SEARCH, lo_q <= hi_q, "search bounds crossed")
  `TST_ASSERT_NXT(a_done_holds, state_q == S_DONE && !res_ready_i, state_q == S_DONE,
                  "result dropped while output full")

endmodule

// ===== hdl/team_slot_table_top.sv =====
// top level of the team slot table: ports, config register and output register
//
// Requests arrive on the in channel (in_valid_i / in_stall_o) with func_i,
// team_id_i, slot_index_i and position_i; one result per request leaves on
// the out channel (out_valid_o / out_stall_i) with status_o, slot_out_o and
// position_out_o. A request is taken when valid is high and stall is low.
// cfg_we_i writes cfg_wdata_i into the all-team id; the user writes it only
// while idle, the block does not enforce this. One request is worked on at
// a time; in_stall_o is high until the sequencer has handed its result to
// the output register. Allocate passes S_ALLOC (skipped when full); recycle
// shifts each later entry down one place in S_SHIFT (at most SLOTS-1);
// convert of the all-team id or on an empty table goes straight to S_DONE,
// else it runs S_SEARCH and S_CMP per search step, then S_FINAL; an unused
// func code goes to S_DONE directly. The table memory moves one entry per
// cycle through its single read and write port, which sets the recycle time.
// The output register holds a result while out_stall_i is high; the next
// request can be accepted meanwhile and its result waits in the sequencer.
// Reset empties the table, fills the free stack with 0..SLOTS-1 (0 on top)
// and clears the all-team id; no clearing pass is needed.
module team_slot_table_top import tst_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [FUNC_W-1:0]   func_i,
  input  logic [ID_W-1:0]     team_id_i,
  input  logic [FIELD_W-1:0]  slot_index_i,
  input  logic [FIELD_W-1:0]  position_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [FIELD_W-1:0]  slot_out_o,
  output logic [FIELD_W-1:0]  position_out_o,
  input  logic                cfg_we_i,
  input  logic [ID_W-1:0]     cfg_wdata_i
);

  logic [ID_W-1:0] all_team_id_q;
  logic            out_valid_q;
  res_t            out_res_q;
  logic            busy;
  logic            start;
  logic            res_valid;
  logic            res_ready;
  res_t            res;
  req_t            req;

  assign req       = '{func: func_i, team_id: team_id_i, slot_index: slot_index_i,
                       position: position_i};
  assign start     = in_valid_i && !busy;
  assign res_ready = !out_valid_q || !out_stall_i;

  tst_ctrl #(.SLOTS(SLOTS)) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .req_i         (req),
    .all_team_id_i (all_team_id_q),
    .busy_o        (busy),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .res_ready_i   (res_ready)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      all_team_id_q <= '0;
    end else if (cfg_we_i) begin
      all_team_id_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  assign in_stall_o     = busy;
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_res_q.status;
  assign slot_out_o     = out_res_q.slot_out;
  assign position_out_o = out_res_q.position_out;

endmodule

// ===== tb/tb_team_slot_table_top.sv =====
// self-checking testbench of the team slot table: directed rows, then random request episodes
`timescale 1ns / 100ps

module tb_team_slot_table_top;
  import tst_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 100;
  localparam int unsigned PHASE_ITEMS = 110;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [FUNC_W-1:0]   func_i = '0;
  logic [ID_W-1:0]     team_id_i = '0;
  logic [FIELD_W-1:0]  slot_index_i = '0;
  logic [FIELD_W-1:0]  position_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [FIELD_W-1:0]  slot_out_o;
  logic [FIELD_W-1:0]  position_out_o;
  logic                cfg_we_i = 1'b0;
  logic [ID_W-1:0]     cfg_wdata_i = '0;

  team_slot_table_top #(.SLOTS(SLOTS_DEF)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .team_id_i      (team_id_i),
    .slot_index_i   (slot_index_i),
    .position_i     (position_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .slot_out_o     (slot_out_o),
    .position_out_o (position_out_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow copy of the free stack, the id table and the all-team id
  logic [FIELD_W-1:0] free_slots [SLOTS_DEF];
  int unsigned        free_depth;
  logic [ID_W-1:0]    team_ids [SLOTS_DEF];
  logic [FIELD_W-1:0] team_slots [SLOTS_DEF];
  int unsigned        team_len;
  logic [ID_W-1:0]    all_team;

  res_t        pending_results[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_left = 0;
  bit          calm = 1'b0;
  logic [ID_W-1:0] next_id = '0;

  typedef struct {
    req_t rq;
    bit   fixed;
    res_t want;
  } dir_row_t;

  dir_row_t dir_rows[$];

  task automatic clear_shadow();
    int unsigned i;
    for (i = 0; i < SLOTS_DEF; i++) begin
      free_slots[i] = FIELD_W'(SLOTS_DEF - 1 - i);
    end
    free_depth = SLOTS_DEF;
    team_len = 0;
    all_team = '0;
  endtask

  function automatic res_t apply_team_request(req_t r);
    res_t o;
    int unsigned i, lo, hi, mid, p;
    o = '0;
    o.status = ST_MISS;
    case (r.func)
      FUNC_ALLOC: begin
        if (free_depth == 0 || team_len >= SLOTS_DEF) begin
          o.status = ST_FULL;
        end else begin
          free_depth--;
          p = team_len;
          team_ids[p] = r.team_id;
          team_slots[p] = free_slots[free_depth];
          team_len++;
          o.status = ST_OK;
          o.slot_out = team_slots[p];
          o.position_out = FIELD_W'(p);
        end
      end
      FUNC_RECYCLE: begin
        if (team_len != 0) begin
          if (free_depth < SLOTS_DEF) begin
            free_slots[free_depth] = r.slot_index;
            free_depth++;
          end
          for (i = 32'(r.position); i + 1 < team_len; i++) begin
            team_ids[i] = team_ids[i + 1];
            team_slots[i] = team_slots[i + 1];
          end
          team_len--;
          o.status = ST_OK;
        end
      end
      FUNC_CONVERT: begin
        if (r.team_id == all_team) begin
          o.status = ST_OK;
        end else if (team_len != 0) begin
          lo = 0;
          hi = team_len - 1;
          while (lo < hi) begin
            mid = (lo + hi) >> 1;
            if (team_ids[mid] < r.team_id) lo = mid + 1;
            else hi = mid;
          end
          if (team_ids[lo] == r.team_id) begin
            o.status = ST_OK;
            o.slot_out = team_slots[lo];
            o.position_out = FIELD_W'(lo);
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic req_t mk_req(logic [FUNC_W-1:0] f, logic [ID_W-1:0] id,
                                  logic [FIELD_W-1:0] s, logic [FIELD_W-1:0] p);
    req_t r;
    r.func = f;
    r.team_id = id;
    r.slot_index = s;
    r.position = p;
    return r;
  endfunction

  task automatic add_row(logic [FUNC_W-1:0] f, logic [ID_W-1:0] id,
                         logic [FIELD_W-1:0] s, logic [FIELD_W-1:0] p, bit fixed,
                         logic [STATUS_W-1:0] st, logic [FIELD_W-1:0] so,
                         logic [FIELD_W-1:0] po);
    dir_row_t row;
    row.rq = mk_req(f, id, s, p);
    row.fixed = fixed;
    row.want.status = st;
    row.want.slot_out = so;
    row.want.position_out = po;
    dir_rows.push_back(row);
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // drive one request, hold it until taken, then predict its result
  task automatic send_request(req_t rq, bit fixed, res_t want);
    res_t got;
    int unsigned gap;
    in_valid_i <= 1'b1;
    func_i <= rq.func;
    team_id_i <= rq.team_id;
    slot_index_i <= rq.slot_index;
    position_i <= rq.position;
    do @(posedge clk_i); while (in_stall_o);
    got = apply_team_request(rq);
    pending_results.push_back(fixed ? want : got);
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_all_team(logic [ID_W-1:0] v);
    wait_results_drained();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    all_team = v;
    cfg_we_i <= 1'b0;
  endtask

  // ids rise so the table stays sorted; restart somewhere random once it empties
  function automatic req_t next_alloc();
    int unsigned nxt;
    if (team_len == 0) next_id = ID_W'($urandom_range(0, 40000));
    nxt = next_id + $urandom_range(1, 900);
    next_id = (nxt > 16'hFFFF) ? 16'hFFFF : ID_W'(nxt);
    return mk_req(FUNC_ALLOC, next_id, FIELD_W'($urandom), FIELD_W'($urandom));
  endfunction

  function automatic req_t recycle_entry();
    int unsigned p;
    if (team_len == 0) return mk_req(FUNC_RECYCLE, ID_W'($urandom), FIELD_W'($urandom),
                                     FIELD_W'($urandom));
    p = $urandom_range(0, team_len - 1);
    return mk_req(FUNC_RECYCLE, ID_W'($urandom), team_slots[p], FIELD_W'(p));
  endfunction

  function automatic req_t mixed_req();
    int unsigned r, c;
    logic [ID_W-1:0] id;
    r = $urandom_range(0, 99);
    if (r < 35) return next_alloc();
    if (r < 60) return recycle_entry();
    if (r < 90) begin
      c = $urandom_range(0, 99);
      if (c < 60 && team_len != 0) id = team_ids[$urandom_range(0, team_len - 1)];
      else if (c < 85) id = ID_W'($urandom);
      else id = all_team;
      return mk_req(FUNC_CONVERT, id, FIELD_W'($urandom), FIELD_W'($urandom));
    end
    if (r < 95) return mk_req(FUNC_RECYCLE, ID_W'($urandom), FIELD_W'($urandom),
                              FIELD_W'($urandom));
    return mk_req(FUNC_UNUSED, ID_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom));
  endfunction

  task automatic run_random_phase(int unsigned n_items);
    int unsigned sent, kind, burst;
    res_t none;
    sent = 0;
    none = '0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 9);
      calm = ($urandom_range(0, 5) == 0);
      if (kind == 0) begin
        // fill the table, then run into the full case
        while (team_len < SLOTS_DEF) begin
          send_request(next_alloc(), 1'b0, none);
          sent++;
        end
        repeat ($urandom_range(1, 2)) begin
          send_request(next_alloc(), 1'b0, none);
          sent++;
        end
      end else if (kind == 1) begin
        // drain to empty, then one recycle on the empty table
        while (team_len != 0) begin
          send_request(recycle_entry(), 1'b0, none);
          sent++;
        end
        send_request(recycle_entry(), 1'b0, none);
        sent++;
      end else begin
        burst = $urandom_range(8, 20);
        repeat (burst) begin
          send_request(mixed_req(), 1'b0, none);
          sent++;
        end
      end
    end
    calm = 1'b0;
  endtask

  // result side: random stall bursts, compare each taken result with the oldest prediction
  always @(posedge clk_i) begin : result_side
    res_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $error("result with no request waiting: status %0d slot %0d position %0d",
                 status_o, slot_out_o, position_out_o);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            mismatches++;
          end
          if (slot_out_o !== want.slot_out) begin
            $error("slot_out: expected %0d, got %0d", want.slot_out, slot_out_o);
            mismatches++;
          end
          if (position_out_o !== want.position_out) begin
            $error("position_out: expected %0d, got %0d", want.position_out, position_out_o);
            mismatches++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 99) < 25) begin
        stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) : $urandom_range(9, 39);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL team_slot_table_top");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned i;
    clear_shadow();

    // directed rows, written against the reset state with all-team id 0
    add_row(FUNC_RECYCLE, 16'h0000, 6'd5,  6'd0,  1, ST_MISS, 6'd0, 6'd0);
    add_row(FUNC_CONVERT, 16'h0000, 6'd0,  6'd0,  1, ST_OK,   6'd0, 6'd0);
    add_row(FUNC_CONVERT, 16'hFFFF, 6'd0,  6'd0,  1, ST_MISS, 6'd0, 6'd0);
    add_row(FUNC_ALLOC,   16'h0000, 6'h3F, 6'h3F, 1, ST_OK,   6'd0, 6'd0);
    add_row(FUNC_ALLOC,   16'h0020, 6'h3F, 6'h3F, 1, ST_OK,   6'd1, 6'd1);
    add_row(FUNC_ALLOC,   16'h0030, 6'd0,  6'd0,  1, ST_OK,   6'd2, 6'd2);
    add_row(FUNC_CONVERT, 16'h0020, 6'd0,  6'd0,  0, ST_OK,   6'd0, 6'd0);
    add_row(FUNC_CONVERT, 16'h0030, 6'h3F, 6'h3F, 0, ST_OK,   6'd0, 6'd0);
    add_row(FUNC_CONVERT, 16'h0000, 6'd0,  6'd0,  1, ST_OK,   6'd0, 6'd0);
    add_row(FUNC_CONVERT, 16'h0025, 6'd0,  6'd0,  0, ST_OK,   6'd0, 6'd0);
    add_row(FUNC_CONVERT, 16'hFFFF, 6'd0,  6'd0,  0, ST_OK,   6'd0, 6'd0);
    add_row(FUNC_UNUSED,  16'hFFFF, 6'h3F, 6'h3F, 1, ST_MISS, 6'd0, 6'd0);
    add_row(FUNC_RECYCLE, 16'hFFFF, 6'd0,  6'd0,  1, ST_OK,   6'd0, 6'd0);
    add_row(FUNC_CONVERT, 16'h0020, 6'd0,  6'd0,  0, ST_OK,   6'd0, 6'd0);
    add_row(FUNC_ALLOC,   16'hFFFF, 6'd0,  6'd0,  0, ST_OK,   6'd0, 6'd0);
    // position past the end drops the last entry
    add_row(FUNC_RECYCLE, 16'h0000, 6'h3F, 6'h3F, 1, ST_OK,   6'd0, 6'd0);
    add_row(FUNC_CONVERT, 16'hFFFF, 6'd0,  6'd0,  0, ST_OK,   6'd0, 6'd0);
    add_row(FUNC_CONVERT, 16'h0030, 6'd0,  6'd0,  0, ST_OK,   6'd0, 6'd0);
    add_row(FUNC_ALLOC,   16'h8000, 6'd0,  6'd0,  0, ST_OK,   6'd0, 6'd0);
    add_row(FUNC_RECYCLE, 16'h0000, 6'h2A, 6'd0,  0, ST_OK,   6'd0, 6'd0);
    add_row(FUNC_CONVERT, 16'h8000, 6'd0,  6'd0,  0, ST_OK,   6'd0, 6'd0);
    add_row(FUNC_RECYCLE, 16'h0000, 6'd1,  6'd0,  0, ST_OK,   6'd0, 6'd0);
    add_row(FUNC_RECYCLE, 16'h0000, 6'd2,  6'd0,  0, ST_OK,   6'd0, 6'd0);
    add_row(FUNC_CONVERT, 16'h0030, 6'd0,  6'd0,  0, ST_OK,   6'd0, 6'd0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_all_team(16'h0000);
    for (i = 0; i < dir_rows.size(); i++) begin
      send_request(dir_rows[i].rq, dir_rows[i].fixed, dir_rows[i].want);
    end

    write_all_team(16'hFFFF);
    run_random_phase(PHASE_ITEMS);
    write_all_team(ID_W'($urandom));
    run_random_phase(PHASE_ITEMS);
    write_all_team(16'h0000);
    run_random_phase(PHASE_ITEMS);
    write_all_team(ID_W'($urandom_range(1, 16'hFFFE)));
    run_random_phase(PHASE_ITEMS);

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS team_slot_table_top");
    end else begin
      $display("FAIL team_slot_table_top");
    end
    $finish;
  end

endmodule

// ===== team_slot_table_top.f =====
+incdir+hdl
hdl/tst_pkg.sv
hdl/tst_ram.sv
hdl/tst_ctrl.sv
hdl/team_slot_table_top.sv
tb/tb_team_slot_table_top.sv
